>>> rtl/core/rot90_pkg.sv
// Shared types and constants for the clockwise matrix rotation block.
package rot90_pkg;

  // Width of the side-length register and of a side value.
  localparam int unsigned SIDE_W = 4;

  // Register map.
  localparam logic [0:0] REG_ADDR_SIDE_LEN = 1'b0;

  // Side length after reset.
  localparam logic [SIDE_W-1:0] SIDE_LEN_RESET = 4'd8;

  // Number of store banks, one matrix per bank.
  localparam logic [1:0] BANK_COUNT = 2'd2;

  // A fully loaded matrix waiting to be read out.
  typedef struct packed {
    logic              bank;
    logic [SIDE_W-1:0] side;
  } job_t;

  // Read-out sequencer states.
  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_t;

endpackage

>>> rtl/core/rot90_front.sv
// Input side: writes elements into the store and posts a job per full matrix.
module rot90_front #(
  parameter int unsigned MAX_SIDE      = 8,
  parameter int unsigned ELEMENT_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            clear,
  input  logic [rot90_pkg::SIDE_W-1:0]    side,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [31:0]              in_element_value,
  output logic                            wr_en,
  output logic [((MAX_SIDE > 1) ? $clog2(MAX_SIDE * MAX_SIDE) : 1):0] wr_addr,
  output logic [ELEMENT_WIDTH-1:0]        wr_data,
  output logic                            job_push,
  output rot90_pkg::job_t                 job,
  input  logic                            bank_release
);

  localparam int unsigned IDX_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE * MAX_SIDE) : 1;
  localparam int unsigned CNT_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;

  logic [CNT_W-1:0] col_r, col_nxt;
  logic [CNT_W-1:0] row_r, row_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             bank_r, bank_nxt;
  logic [1:0]       busy_r, busy_nxt;
  logic [CNT_W-1:0] side_m1;
  logic             accept;
  logic             last_elem;

  // A bank is busy from its last element until its last read is issued.
  assign in_ready  = (busy_r != rot90_pkg::BANK_COUNT);
  assign accept    = in_valid && in_ready;
  assign side_m1   = CNT_W'(side - rot90_pkg::SIDE_W'(1));
  assign last_elem = (col_r == side_m1) && (row_r == side_m1);

  // Store write port: elements keep their low ELEMENT_WIDTH bits.
  assign wr_en    = accept;
  assign wr_addr  = {bank_r, idx_r};
  assign wr_data  = ELEMENT_WIDTH'({1'b0, in_element_value});

  // Job posted with the final element of a matrix.
  assign job_push  = accept && last_elem;
  assign job.bank  = bank_r;
  assign job.side  = side;

  // Row-major position tracking.
  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    idx_nxt  = idx_r;
    bank_nxt = bank_r;
    if (clear) begin
      col_nxt = '0;
      row_nxt = '0;
      idx_nxt = '0;
    end else if (accept) begin
      idx_nxt = IDX_W'(idx_r + 1'b1);
      if (col_r == side_m1) begin
        col_nxt = '0;
        if (row_r == side_m1) begin
          row_nxt  = '0;
          idx_nxt  = '0;
          bank_nxt = ~bank_r;
        end else begin
          row_nxt = CNT_W'(row_r + 1'b1);
        end
      end else begin
        col_nxt = CNT_W'(col_r + 1'b1);
      end
    end
  end

  // Outstanding bank count.
  always_comb begin
    busy_nxt = busy_r;
    if (job_push && !bank_release) begin
      busy_nxt = 2'(busy_r + 1'b1);
    end else if (!job_push && bank_release) begin
      busy_nxt = 2'(busy_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      idx_r  <= '0;
      bank_r <= 1'b0;
      busy_r <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      idx_r  <= idx_nxt;
      bank_r <= bank_nxt;
      busy_r <= busy_nxt;
    end
  end

endmodule

>>> rtl/core/rot90_jobq.sv
// Two-entry job queue between the load side and the read-out side.
module rot90_jobq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  rot90_pkg::job_t push_job,
  input  logic            pop,
  output logic            not_empty,
  output rot90_pkg::job_t head_job
);

  rot90_pkg::job_t entry_r [2];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      count_r, count_nxt;

  assign not_empty = (count_r != 2'd0);
  assign head_job  = entry_r[rd_ptr_r];

  // Pointer and occupancy update; the load side never overfills it.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = 2'(count_r + 1'b1);
    end else if (!push && pop) begin
      count_nxt = 2'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

>>> rtl/core/rot90_back.sv
// Read-out side: holds the two-bank store and walks it in rotated order.
module rot90_back #(
  parameter int unsigned MAX_SIDE      = 8,
  parameter int unsigned ELEMENT_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     wr_en,
  input  logic [((MAX_SIDE > 1) ? $clog2(MAX_SIDE * MAX_SIDE) : 1):0] wr_addr,
  input  logic [ELEMENT_WIDTH-1:0] wr_data,
  input  logic                     job_valid,
  input  rot90_pkg::job_t          job,
  output logic                     job_pop,
  output logic                     bank_release,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [31:0]       out_rotated_value,
  output logic                     out_last_of_matrix
);

  localparam int unsigned IDX_W   = (MAX_SIDE > 1) ? $clog2(MAX_SIDE * MAX_SIDE) : 1;
  localparam int unsigned CNT_W   = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int unsigned DEPTH   = 2 ** (IDX_W + 1);
  localparam int unsigned PROD_W  = 2 * rot90_pkg::SIDE_W;

  logic [ELEMENT_WIDTH-1:0]  store_mem [DEPTH];
  logic [ELEMENT_WIDTH-1:0]  rd_data_r;

  rot90_pkg::back_state_t    state_r, state_nxt;
  logic [rot90_pkg::SIDE_W-1:0] side_r, side_nxt;
  logic                      bank_r, bank_nxt;
  logic [CNT_W-1:0]          row_r, row_nxt;
  logic [CNT_W-1:0]          col_r, col_nxt;
  logic [IDX_W-1:0]          src_r, src_nxt;
  logic [IDX_W-1:0]          top_r, top_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      last_r, last_nxt;
  logic                      rd_en;
  logic [CNT_W-1:0]          side_m1;
  logic [PROD_W-1:0]         top_prod;

  // Start of the bottom row, (N-1)*N, for the incoming job.
  assign top_prod = PROD_W'(job.side - rot90_pkg::SIDE_W'(1)) * PROD_W'(job.side);
  assign side_m1  = CNT_W'(side_r - rot90_pkg::SIDE_W'(1));

  // Sequencer: each issued read becomes one result in the output register.
  always_comb begin
    state_nxt     = state_r;
    side_nxt      = side_r;
    bank_nxt      = bank_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    src_nxt       = src_r;
    top_nxt       = top_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && !out_ready;
    job_pop       = 1'b0;
    rd_en         = 1'b0;
    bank_release  = 1'b0;
    case (state_r)
      rot90_pkg::BK_IDLE: begin
        if (job_valid) begin
          job_pop   = 1'b1;
          side_nxt  = job.side;
          bank_nxt  = job.bank;
          row_nxt   = '0;
          col_nxt   = '0;
          top_nxt   = IDX_W'(top_prod);
          src_nxt   = IDX_W'(top_prod);
          state_nxt = rot90_pkg::BK_RUN;
        end
      end
      rot90_pkg::BK_RUN: begin
        if (!out_valid_r || out_ready) begin
          rd_en         = 1'b1;
          out_valid_nxt = 1'b1;
          last_nxt      = (col_r == side_m1) && (row_r == side_m1);
          if (col_r == side_m1) begin
            // Next output row reads the next column, bottom to top.
            col_nxt = '0;
            src_nxt = IDX_W'(top_r + IDX_W'(row_r) + 1'b1);
            if (row_r == side_m1) begin
              bank_release = 1'b1;
              state_nxt    = rot90_pkg::BK_IDLE;
            end else begin
              row_nxt = CNT_W'(row_r + 1'b1);
            end
          end else begin
            col_nxt = CNT_W'(col_r + 1'b1);
            src_nxt = IDX_W'(src_r - IDX_W'(side_r));
          end
        end
      end
      default: begin
        state_nxt = rot90_pkg::BK_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rot90_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Sequencer payload registers.
  always_ff @(posedge clk) begin
    side_r <= side_nxt;
    bank_r <= bank_nxt;
    row_r  <= row_nxt;
    col_r  <= col_nxt;
    src_r  <= src_nxt;
    top_r  <= top_nxt;
    last_r <= last_nxt;
  end

  // Element store: one write port for loading, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= store_mem[{bank_r, src_r}];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_rotated_value  = 32'({1'b0, rd_data_r});
  assign out_last_of_matrix = last_r;

endmodule

>>> rtl/core/matrix_rotate_90_clockwise.sv
// Top level of the clockwise matrix rotation block with its register port.
//
//   Channel  Direction  Handshake            Payload
//   in_      input      in_valid/in_ready    in_element_value
//   out_     output     out_valid/out_ready  out_rotated_value, out_last_of_matrix
//   cfg_     input      APB write/read       side length at byte address 0
//
// One element is loaded per cycle while in_ready is high, and within a matrix one
// result is sent per cycle while out_ready is high. The first result of a matrix
// follows the transfer of its final element through the job queue, the job
// hand-off and the registered store read. The store has two banks, so a matrix
// loads while the one before it drains; a third matrix waits until a bank is free.
// Reset clears all control state and sets the side length to 8.
// A stalled output holds its result while further reads wait.
module matrix_rotate_90_clockwise #(
  parameter int unsigned MAX_SIDE      = 8,
  parameter int unsigned ELEMENT_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_element_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_rotated_value,
  output logic               out_last_of_matrix,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [0:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  localparam int unsigned IDX_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE * MAX_SIDE) : 1;

  logic [rot90_pkg::SIDE_W-1:0] side_len_r, side_len_nxt;
  logic [rot90_pkg::SIDE_W-1:0] side;
  logic                         size_wr;
  logic                         wr_en;
  logic [IDX_W:0]               wr_addr;
  logic [ELEMENT_WIDTH-1:0]     wr_data;
  logic                         job_push;
  rot90_pkg::job_t              push_job;
  logic                         job_pop;
  logic                         job_valid;
  rot90_pkg::job_t              head_job;
  logic                         bank_release;

  // Register port; every transfer completes in its access cycle.
  assign cfg_pready = 1'b1;
  assign size_wr    = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr == rot90_pkg::REG_ADDR_SIDE_LEN);
  assign side_len_nxt = size_wr ? cfg_pwdata[rot90_pkg::SIDE_W-1:0] : side_len_r;
  assign cfg_prdata = (cfg_paddr == rot90_pkg::REG_ADDR_SIDE_LEN) ?
                      32'(side_len_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_len_r <= rot90_pkg::SIDE_LEN_RESET;
    end else begin
      side_len_r <= side_len_nxt;
    end
  end

  // Side in use: zero counts as one, anything above the maximum as the maximum.
  always_comb begin
    if (side_len_r == '0) begin
      side = rot90_pkg::SIDE_W'(1);
    end else if (side_len_r > rot90_pkg::SIDE_W'(MAX_SIDE)) begin
      side = rot90_pkg::SIDE_W'(MAX_SIDE);
    end else begin
      side = side_len_r;
    end
  end

  rot90_front #(
    .MAX_SIDE      (MAX_SIDE),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .clear            (size_wr),
    .side             (side),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_element_value (in_element_value),
    .wr_en            (wr_en),
    .wr_addr          (wr_addr),
    .wr_data          (wr_data),
    .job_push         (job_push),
    .job              (push_job),
    .bank_release     (bank_release)
  );

  rot90_jobq u_jobq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_job  (push_job),
    .pop       (job_pop),
    .not_empty (job_valid),
    .head_job  (head_job)
  );

  rot90_back #(
    .MAX_SIDE      (MAX_SIDE),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .wr_en              (wr_en),
    .wr_addr            (wr_addr),
    .wr_data            (wr_data),
    .job_valid          (job_valid),
    .job                (head_job),
    .job_pop            (job_pop),
    .bank_release       (bank_release),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_rotated_value  (out_rotated_value),
    .out_last_of_matrix (out_last_of_matrix)
  );

endmodule

>>> bench/testbench.sv
// Self-checking testbench for the clockwise matrix rotation block.
module testbench;

  localparam int unsigned SIDE_MAX        = 8;
  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned DRAIN_CYCLES    = 8;
  localparam int unsigned HOLD_OFF_CYCLES = 400;

  // One element of the rotated matrix as the block should send it.
  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
  } rotated_elem_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] in_element_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_rotated_value;
  logic               out_last_of_matrix;
  logic               cfg_psel = 1'b0;
  logic               cfg_penable = 1'b0;
  logic               cfg_pwrite = 1'b0;
  logic [0:0]         cfg_paddr = rot90_pkg::REG_ADDR_SIDE_LEN;
  logic [31:0]        cfg_pwdata = '0;
  logic [31:0]        cfg_prdata;
  logic               cfg_pready;

  // Elements waiting to be sent and rotated elements still to arrive.
  logic signed [31:0] element_feed_q[$];
  rotated_elem_t      rotated_due_q[$];

  // Our own copy of the loaded matrix, its fill level and the side register.
  logic signed [31:0] matrix_copy [SIDE_MAX*SIDE_MAX];
  logic [6:0]         elems_taken = '0;
  logic [rot90_pkg::SIDE_W-1:0] side_setting = rot90_pkg::SIDE_LEN_RESET;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_off_kick = 1'b0;
  int unsigned hold_off_left = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  matrix_rotate_90_clockwise u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_element_value   (in_element_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_rotated_value  (out_rotated_value),
    .out_last_of_matrix (out_last_of_matrix),
    .cfg_psel           (cfg_psel),
    .cfg_penable        (cfg_penable),
    .cfg_pwrite         (cfg_pwrite),
    .cfg_paddr          (cfg_paddr),
    .cfg_pwdata         (cfg_pwdata),
    .cfg_prdata         (cfg_prdata),
    .cfg_pready         (cfg_pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // A side of zero works as one, and anything past the maximum as the maximum.
  function automatic int unsigned effective_side(input logic [rot90_pkg::SIDE_W-1:0] s);
    if (s == '0) return 1;
    if (s > SIDE_MAX) return SIDE_MAX;
    return 32'(s);
  endfunction

  // Stores one accepted element; on the last one, queues the rotated matrix.
  task automatic take_element(input logic signed [31:0] v);
    int unsigned   n;
    int unsigned   total;
    int unsigned   src;
    rotated_elem_t e;
    n     = effective_side(side_setting);
    total = n * n;
    if (elems_taken >= total) elems_taken = '0;
    matrix_copy[elems_taken[5:0]] = v;
    elems_taken = elems_taken + 7'd1;
    if (elems_taken == total) begin
      elems_taken = '0;
      for (int unsigned r = 0; r < n; r++) begin
        for (int unsigned c = 0; c < n; c++) begin
          src     = (n - 1 - c) * n + r;
          e.value = matrix_copy[src[5:0]];
          e.last  = (r * n + c + 1 == total);
          rotated_due_q.push_back(e);
        end
      end
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // Mostly random content with the extremes mixed in.
  function automatic logic signed [31:0] random_element();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return 32'sh0000_0000;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Writes the side register with a setup and an access cycle.
  task automatic write_side(input logic [rot90_pkg::SIDE_W-1:0] s);
    logic [31:0] d;
    d              = $urandom;
    d[rot90_pkg::SIDE_W-1:0] = s;
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= rot90_pkg::REG_ADDR_SIDE_LEN;
    cfg_pwdata  <= d;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    // A size write also drops any partly loaded matrix.
    side_setting = s;
    elems_taken  = '0;
  endtask

  // Waits until every element went in and every result came out; checked
  // between edges so that all updates of the last edge are visible.
  task automatic wait_idle();
    while (element_feed_q.size() != 0 || in_valid || rotated_due_q.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One random phase: side, idling mode, whole matrices, an optional partial
  // matrix left behind, and an optional long receiver hold-off.
  task automatic run_phase(input logic [rot90_pkg::SIDE_W-1:0] s,
                           input int unsigned idle_mode,
                           input int unsigned matrices, input bit partial,
                           input bit squeeze);
    int unsigned n;
    wait_idle();
    write_side(s);
    case (idle_mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
      default: begin send_idle_pct = 36; recv_stall_pct = 36; end
    endcase
    if (squeeze) begin
      hold_off_kick <= 1'b1;
      @(posedge clk);
      hold_off_kick <= 1'b0;
    end
    n = effective_side(s);
    repeat (matrices * n * n) element_feed_q.push_back(random_element());
    if (partial && n > 1)
      repeat ($urandom_range(1, n * n - 1)) element_feed_q.push_back(random_element());
  endtask

  // Driver: offers the next pending element once the current transfer is done.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (element_feed_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid         <= 1'b1;
        in_element_value <= element_feed_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Each input transfer feeds the predictor.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) take_element(in_element_value);
  end

  // Long receiver hold-off, counted down on its own.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_off_left <= 0;
    end else if (hold_off_kick) begin
      hold_off_left <= HOLD_OFF_CYCLES;
    end else if (hold_off_left != 0) begin
      hold_off_left <= hold_off_left - 1;
    end
  end

  // Receiver: random stalls on top of the hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= (hold_off_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: each output transfer is checked against the oldest expectation.
  always @(posedge clk) begin : out_check
    rotated_elem_t want;
    if (rst_n && out_valid && out_ready) begin
      if (rotated_due_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d", out_rotated_value));
      end else begin
        want = rotated_due_q.pop_front();
        if (out_rotated_value !== want.value)
          report_mismatch($sformatf("rotated_value %0d, expected %0d",
                                    out_rotated_value, want.value));
        if (out_last_of_matrix !== want.last)
          report_mismatch($sformatf("last_of_matrix %0b, expected %0b",
                                    out_last_of_matrix, want.last));
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // A few elements at the reset side; they must not complete a matrix.
    element_feed_q.push_back(32'sh7FFF_FFFF);
    element_feed_q.push_back(32'sh8000_0000);
    element_feed_q.push_back(-32'sd1);
    wait_idle();

    // Side one: every element is its own matrix.
    write_side(4'd1);
    element_feed_q.push_back(32'sh7FFF_FFFF);
    element_feed_q.push_back(32'sh8000_0000);
    element_feed_q.push_back(32'sh0000_0000);
    element_feed_q.push_back(-32'sd1);
    wait_idle();

    // Side two with alternating bit patterns.
    write_side(4'd2);
    element_feed_q.push_back(32'sh5555_5555);
    element_feed_q.push_back(32'shAAAA_AAAA);
    element_feed_q.push_back(32'sh0000_0001);
    element_feed_q.push_back(32'shFFFF_FFFE);
    wait_idle();

    // Odd side: the center element keeps its place.
    write_side(4'd3);
    for (int i = 0; i < 9; i++) element_feed_q.push_back(32'sh1000_0000 * (i - 4) + i);
    wait_idle();

    // A partial matrix dropped by a size write, then a side of zero.
    element_feed_q.push_back(32'sh1234_5678);
    element_feed_q.push_back(32'shFEDC_BA98);
    wait_idle();
    write_side(4'd0);
    element_feed_q.push_back(32'sh0BAD_F00D);

    // Random phases over sides, idling modes and partial matrices.
    run_phase(4'd8,  0, 3,  1'b0, 1'b1);
    run_phase(4'd1,  2, 8,  1'b0, 1'b0);
    run_phase(4'd5,  3, 1,  1'b1, 1'b0);
    run_phase(4'd0,  0, 8,  1'b0, 1'b0);
    run_phase(4'd2,  1, 3,  1'b1, 1'b0);
    run_phase(4'd15, 2, 1,  1'b0, 1'b0);
    run_phase(4'd7,  3, 1,  1'b1, 1'b0);
    run_phase(4'd4,  3, 1,  1'b0, 1'b0);
    run_phase(4'd6,  1, 1,  1'b1, 1'b0);
    run_phase(4'd3,  2, 2,  1'b0, 1'b0);
    wait_idle();

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
